FILE: rtl/core/slab_pkg.sv
// ----------------------------------------------------------------------------
// slab_pkg
// shared types and default constants for the size-class slab pool allocator
// ----------------------------------------------------------------------------
package slab_pkg;

  localparam int NUM_POOLS_DEF       = 4;
  localparam int SLOTS_PER_POOL_DEF  = 128;
  localparam int MAX_POOLED_SIZE_DEF = 10;

  // fixed field widths of the transaction payloads
  localparam int FUNC_W  = 1;
  localparam int SIZE_W  = 4;
  localparam int INDEX_W = 9;
  localparam int STAT_W  = 3;

  typedef enum logic [0:0] {
    FN_REQUEST = 1'b0,
    FN_RELEASE = 1'b1
  } slab_func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_FROM_LIST = 3'd0,
    ST_NEW_POOL  = 3'd1,
    ST_NO_SLOT   = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_NOT_POOL  = 3'd4,
    ST_FULL      = 3'd5
  } slab_status_t;

endpackage

FILE: rtl/core/slab_list_ram.sv
// ----------------------------------------------------------------------------
// slab_list_ram
// single-port free-list storage, one region per pool, registered read data
// ----------------------------------------------------------------------------
module slab_list_ram #(
  parameter int ADDR_W = 9,
  parameter int DATA_W = 7
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
  end

  // read data holds when the port is idle
  always_ff @(posedge clk) begin
    if (en && !we) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/size_class_slab_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// size_class_slab_pool_allocator_top
// slab allocator with NUM_POOLS pools of SLOTS_PER_POOL slots and fifo free lists
// ----------------------------------------------------------------------------
// Each input transaction is a request (grant a slot of a size class) or a
// release (return a slot), selected by in_tuser. Exactly one result
// transaction follows each input transaction, in order, with its status on
// out_tuser. The block takes one transaction per cycle while the output is not
// stalled, and each result passes the decide and result stage registers: the
// decision against the pool table and the free-list ram access happen in the
// same cycle, and the ram read data is registered alongside the result
// register. Throughput is set by the single ram port, which each transaction
// uses at most once (a pop reads it, a release writes it), so back-to-back
// transactions are sustained. Opening a pool does not sweep the ram: slots
// still in their initial order are produced from a per-pool count of list
// writes since the pool was opened, so no clearing pass is needed after
// reset. Output backpressure stalls both stages.
// ----------------------------------------------------------------------------
module size_class_slab_pool_allocator_top
  import slab_pkg::*;
#(
  parameter int NUM_POOLS       = NUM_POOLS_DEF,
  parameter int SLOTS_PER_POOL  = SLOTS_PER_POOL_DEF,
  parameter int MAX_POOLED_SIZE = MAX_POOLED_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [FUNC_W-1:0] in_tuser,   // [0] func
  input  logic [15:0]       in_tdata,   // [3:0] pixel_size, [12:4] tile_index
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [STAT_W-1:0] out_tuser,  // [2:0] status
  output logic [15:0]       out_tdata   // [8:0] granted_index
);

  localparam int POOL_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int SLOT_W = $clog2(SLOTS_PER_POOL);
  localparam int CNT_W  = $clog2(SLOTS_PER_POOL + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int ADDR_W = POOL_W + SLOT_W;

  // pool table
  logic [SIZE_W-1:0] pool_class_r [NUM_POOLS];
  logic [SIZE_W-1:0] pool_class_nxt [NUM_POOLS];
  logic [SLOT_W-1:0] free_head_r [NUM_POOLS];
  logic [SLOT_W-1:0] free_head_nxt [NUM_POOLS];
  logic [CNT_W-1:0]  free_count_r [NUM_POOLS];
  logic [CNT_W-1:0]  free_count_nxt [NUM_POOLS];
  // list writes since the pool was opened, saturating at the pool size
  logic [CNT_W-1:0]  wr_count_r [NUM_POOLS];
  logic [CNT_W-1:0]  wr_count_nxt [NUM_POOLS];

  // decide stage
  logic               a_valid_r;
  logic [FUNC_W-1:0]  a_func_r;
  logic [SIZE_W-1:0]  a_size_r;
  logic [INDEX_W-1:0] a_idx_r;

  // result stage
  logic               b_valid_r;
  slab_status_t       b_status_r;
  logic [INDEX_W-1:0] b_base_r;
  logic [SLOT_W-1:0]  b_fresh_r;
  logic               b_use_mem_r;

  logic               adv;
  logic               active;

  slab_status_t       st;
  logic [INDEX_W-1:0] base;
  logic [SLOT_W-1:0]  fresh;
  logic               use_mem;
  logic               ram_en;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [SLOT_W-1:0]  ram_wdata;
  logic [SLOT_W-1:0]  ram_q;

  logic [SLOT_W-1:0]  slot_out;
  logic [INDEX_W-1:0] granted;

  // the pipe moves unless a finished result is waiting on the output
  assign adv       = !(b_valid_r && !out_tready);
  assign active    = a_valid_r && adv;
  assign in_tready = adv || !a_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_func_r <= in_tuser;
      a_size_r <= in_tdata[3:0];
      a_idx_r  <= in_tdata[12:4];
    end
  end

  // decision logic: one pool lookup, one list update, at most one ram access
  always_comb begin
    logic              found;
    logic              hit;
    logic [SLOT_W-1:0] h;
    logic [SLOT_W-1:0] nk;
    logic [SLOT_W-1:0] rel_slot;
    logic [SUM_W-1:0]  sum;
    logic [SLOT_W-1:0] tail;

    found     = 1'b0;
    hit       = 1'b0;
    h         = '0;
    nk        = '0;
    rel_slot  = '0;
    sum       = '0;
    tail      = '0;
    st        = ST_NO_SLOT;
    base      = '0;
    fresh     = '0;
    use_mem   = 1'b0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      pool_class_nxt[p] = pool_class_r[p];
      free_head_nxt[p]  = free_head_r[p];
      free_count_nxt[p] = free_count_r[p];
      wr_count_nxt[p]   = wr_count_r[p];
    end

    if (active) begin
      if (a_func_r == FN_REQUEST) begin
        if (a_size_r != '0 && a_size_r <= SIZE_W'(MAX_POOLED_SIZE)) begin
          for (int p = 0; p < NUM_POOLS; p++) begin
            if (!found) begin
              if (pool_class_r[p] == a_size_r && free_count_r[p] != '0) begin
                // pop the oldest free slot
                found = 1'b1;
                h  = free_head_r[p];
                nk = (h == SLOT_W'(SLOTS_PER_POOL - 1)) ? '0 : h + 1'b1;
                st       = ST_FROM_LIST;
                base     = INDEX_W'(p * SLOTS_PER_POOL);
                fresh    = nk;
                use_mem  = CNT_W'(nk) < wr_count_r[p];
                ram_en   = use_mem;
                ram_addr = {POOL_W'(p), h};
                free_head_nxt[p]  = nk;
                free_count_nxt[p] = free_count_r[p] - 1'b1;
              end else if (pool_class_r[p] == '0) begin
                // bind an unbound pool, slot 0 granted, the rest queued in order
                found = 1'b1;
                st    = ST_NEW_POOL;
                base  = INDEX_W'(p * SLOTS_PER_POOL);
                pool_class_nxt[p] = a_size_r;
                free_head_nxt[p]  = '0;
                free_count_nxt[p] = CNT_W'(SLOTS_PER_POOL - 1);
                wr_count_nxt[p]   = '0;
              end
            end
          end
        end
      end else begin
        st = ST_NOT_POOL;
        for (int p = 0; p < NUM_POOLS; p++) begin
          if (int'(a_idx_r) >= p * SLOTS_PER_POOL &&
              int'(a_idx_r) < (p + 1) * SLOTS_PER_POOL) begin
            hit      = 1'b1;
            rel_slot = SLOT_W'(int'(a_idx_r) - p * SLOTS_PER_POOL);
            if (a_size_r == '0 || pool_class_r[p] != a_size_r) begin
              st = ST_NOT_POOL;
            end else if (free_count_r[p] == CNT_W'(SLOTS_PER_POOL)) begin
              st = ST_FULL;
            end else begin
              sum = SUM_W'(free_head_r[p]) + SUM_W'(free_count_r[p]);
              if (sum >= SUM_W'(SLOTS_PER_POOL)) begin
                sum = sum - SUM_W'(SLOTS_PER_POOL);
              end
              tail      = sum[SLOT_W-1:0];
              st        = ST_RELEASED;
              ram_en    = 1'b1;
              ram_we    = 1'b1;
              ram_addr  = {POOL_W'(p), tail};
              ram_wdata = rel_slot;
              free_count_nxt[p] = free_count_r[p] + 1'b1;
              if (wr_count_r[p] != CNT_W'(SLOTS_PER_POOL)) begin
                wr_count_nxt[p] = wr_count_r[p] + 1'b1;
              end
            end
          end
        end
        if (!hit) begin
          st = ST_NOT_POOL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        pool_class_r[p] <= '0;
        free_head_r[p]  <= '0;
        free_count_r[p] <= '0;
        wr_count_r[p]   <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        pool_class_r[p] <= pool_class_nxt[p];
        free_head_r[p]  <= free_head_nxt[p];
        free_count_r[p] <= free_count_nxt[p];
        wr_count_r[p]   <= wr_count_nxt[p];
      end
    end
  end

  slab_list_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (SLOT_W)
  ) u_list_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      b_status_r  <= st;
      b_base_r    <= base;
      b_fresh_r   <= fresh;
      b_use_mem_r <= use_mem;
    end
  end

  // slot comes from the ram when written since opening, else the initial order
  assign slot_out   = b_use_mem_r ? ram_q : b_fresh_r;
  assign granted    = b_base_r + INDEX_W'(slot_out);
  assign out_tvalid = b_valid_r;
  assign out_tuser  = b_status_r;
  assign out_tdata  = {7'b0000000, granted};

  // list occupancy never passes the pool size
  for (genvar g = 0; g < NUM_POOLS; g++) begin : g_chk
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
      free_count_r[g] <= CNT_W'(SLOTS_PER_POOL) &&
      wr_count_r[g] <= CNT_W'(SLOTS_PER_POOL))
      else $error("free list count out of range");

    // an unbound pool holds an empty list
    a_unbound_empty : assert property (@(posedge clk) disable iff (!rst_n)
      pool_class_r[g] == '0 |-> free_count_r[g] == '0)
      else $error("unbound pool with free slots");
  end

  // ram read data must hold while a result that uses it waits on the output
  a_ram_hold : assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && b_use_mem_r && !out_tready |=> $stable(ram_q))
    else $error("ram read data changed during stall");

  // only grants carry an index
  a_index_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && b_status_r != ST_FROM_LIST && b_status_r != ST_NEW_POOL
      |-> granted == '0)
    else $error("nonzero index on a non-grant result");

  // a stalled or empty decide stage makes no ram access
  a_stall_state : assert property (@(posedge clk) disable iff (!rst_n)
    !active |-> ram_en == 1'b0)
    else $error("ram access without an active transaction");

endmodule
